FILE: hdl/bklt_pkg.sv
// ----------------------------------------------------------------------------
// bklt_pkg
// Shared constants and types of the bounded keyed list table.
// ----------------------------------------------------------------------------
package bklt_pkg;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned KEY_BITS   = 16;
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned ADDR_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned CAP_W      = 7;
  localparam int unsigned OP_W       = 3;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT    = 3'd0,
    OP_QUERY     = 3'd1,
    OP_REMOVE    = 3'd2,
    OP_GET_FIRST = 3'd3,
    OP_GET_NEXT  = 3'd4,
    OP_CLEAR     = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FETCH,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

FILE: hdl/bklt_in_if.sv
// ----------------------------------------------------------------------------
// bklt_in_if
// Request channel: opcode, key and value with valid/ready.
// ----------------------------------------------------------------------------
interface bklt_in_if;
  logic                            valid;
  logic                            ready;
  logic [bklt_pkg::OP_W-1:0]       opcode;
  logic [bklt_pkg::KEY_BITS-1:0]   in_key;
  logic [bklt_pkg::VALUE_BITS-1:0] in_value;

  modport source (output valid, output opcode, output in_key, output in_value,
                  input ready);
  modport sink   (input valid, input opcode, input in_key, input in_value,
                  output ready);
endinterface

FILE: hdl/bklt_out_if.sv
// ----------------------------------------------------------------------------
// bklt_out_if
// Response channel: status, returned entry and entry count with valid/ready.
// ----------------------------------------------------------------------------
interface bklt_out_if;
  logic                            valid;
  logic                            ready;
  logic                            ok;
  logic [bklt_pkg::KEY_BITS-1:0]   out_key;
  logic [bklt_pkg::VALUE_BITS-1:0] out_value;
  logic [bklt_pkg::CNT_W-1:0]      item_count;

  modport source (output valid, output ok, output out_key, output out_value,
                  output item_count, input ready);
  modport sink   (input valid, input ok, input out_key, input out_value,
                  input item_count, output ready);
endinterface

FILE: hdl/bklt_ram.sv
// ----------------------------------------------------------------------------
// bklt_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bklt_ram #(
  parameter  int unsigned Depth = 64,
  parameter  int unsigned Width = 48,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/bklt_ctrl.sv
// ----------------------------------------------------------------------------
// bklt_ctrl
// Sequencer: decodes a request, scans and compacts the entry RAM, and holds
// the response in an output register.
// ----------------------------------------------------------------------------
module bklt_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [bklt_pkg::CAP_W-1:0]   cap_i,
  bklt_in_if.sink                      req,
  bklt_out_if.source                   rsp,
  output bklt_pkg::ram_req_t           ram_o,
  input  bklt_pkg::entry_t             ram_rdata_i
);

  bklt_pkg::state_e state_q, state_d;
  logic [bklt_pkg::OP_W-1:0]       op_q, op_d;
  logic [bklt_pkg::KEY_BITS-1:0]   key_q, key_d;
  logic [bklt_pkg::CNT_W-1:0]      idx_q, idx_d;
  logic [bklt_pkg::CNT_W-1:0]      count_q, count_d;
  logic [bklt_pkg::CNT_W-1:0]      cursor_q, cursor_d;
  logic                            ok_q, ok_d;
  logic [bklt_pkg::KEY_BITS-1:0]   rk_q, rk_d;
  logic [bklt_pkg::VALUE_BITS-1:0] rv_q, rv_d;
  logic                            ovld_q, ovld_d;
  logic                            ook_q, ook_d;
  logic [bklt_pkg::KEY_BITS-1:0]   okey_q, okey_d;
  logic [bklt_pkg::VALUE_BITS-1:0] oval_q, oval_d;
  logic [bklt_pkg::CNT_W-1:0]      ocnt_q, ocnt_d;
  logic [bklt_pkg::CNT_W-1:0]      eff_cap;
  logic [bklt_pkg::CNT_W-1:0]      idx_inc;
  logic [bklt_pkg::CNT_W-1:0]      idx_inc2;
  logic                            accept;

  // capacity saturates at the table depth
  assign eff_cap  = (32'(cap_i) > bklt_pkg::DEPTH) ? bklt_pkg::CNT_W'(bklt_pkg::DEPTH)
                                                   : bklt_pkg::CNT_W'(cap_i);
  assign idx_inc  = idx_q + bklt_pkg::CNT_W'(1);
  assign idx_inc2 = idx_q + bklt_pkg::CNT_W'(2);
  assign accept   = req.valid && req.ready;

  assign req.ready      = (state_q == bklt_pkg::S_IDLE);
  assign rsp.valid      = ovld_q;
  assign rsp.ok         = ook_q;
  assign rsp.out_key    = okey_q;
  assign rsp.out_value  = oval_q;
  assign rsp.item_count = ocnt_q;

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    key_d    = key_q;
    idx_d    = idx_q;
    count_d  = count_q;
    cursor_d = cursor_q;
    ok_d     = ok_q;
    rk_d     = rk_q;
    rv_d     = rv_q;
    ovld_d   = ovld_q;
    ook_d    = ook_q;
    okey_d   = okey_q;
    oval_d   = oval_q;
    ocnt_d   = ocnt_q;

    ram_o.we    = 1'b0;
    ram_o.waddr = count_q[bklt_pkg::ADDR_W-1:0];
    ram_o.wdata = ram_rdata_i;
    ram_o.raddr = idx_q[bklt_pkg::ADDR_W-1:0];

    if (ovld_q && rsp.ready) begin
      ovld_d = 1'b0;
    end

    case (state_q)
      bklt_pkg::S_IDLE: begin
        if (accept) begin
          op_d    = req.opcode;
          key_d   = req.in_key;
          ok_d    = 1'b0;
          rk_d    = '0;
          rv_d    = '0;
          state_d = bklt_pkg::S_DONE;
          case (req.opcode)
            bklt_pkg::OP_INSERT: begin
              if (count_q < eff_cap) begin
                ram_o.we          = 1'b1;
                ram_o.waddr       = count_q[bklt_pkg::ADDR_W-1:0];
                ram_o.wdata.key   = req.in_key;
                ram_o.wdata.value = req.in_value;
                count_d           = count_q + bklt_pkg::CNT_W'(1);
                ok_d              = 1'b1;
              end
            end
            bklt_pkg::OP_QUERY, bklt_pkg::OP_REMOVE: begin
              if (count_q != '0) begin
                ram_o.raddr = '0;
                idx_d       = '0;
                state_d     = bklt_pkg::S_SCAN_CMP;
              end
            end
            bklt_pkg::OP_GET_FIRST: begin
              if (count_q != '0) begin
                ram_o.raddr = '0;
                cursor_d    = bklt_pkg::CNT_W'(1);
                state_d     = bklt_pkg::S_FETCH;
              end
            end
            bklt_pkg::OP_GET_NEXT: begin
              if (cursor_q < count_q) begin
                ram_o.raddr = cursor_q[bklt_pkg::ADDR_W-1:0];
                cursor_d    = cursor_q + bklt_pkg::CNT_W'(1);
                state_d     = bklt_pkg::S_FETCH;
              end
            end
            bklt_pkg::OP_CLEAR: begin
              if (count_q != '0) begin
                cursor_d = count_q;
              end
              count_d = '0;
              ok_d    = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      bklt_pkg::S_SCAN_RD: begin
        ram_o.raddr = idx_q[bklt_pkg::ADDR_W-1:0];
        state_d     = bklt_pkg::S_SCAN_CMP;
      end

      bklt_pkg::S_SCAN_CMP: begin
        if (ram_rdata_i.key == key_q) begin
          ok_d    = 1'b1;
          rk_d    = ram_rdata_i.key;
          rv_d    = ram_rdata_i.value;
          state_d = bklt_pkg::S_DONE;
          if (op_q == bklt_pkg::OP_REMOVE) begin
            if (idx_inc < count_q) begin
              state_d = bklt_pkg::S_SHIFT_RD;
            end else begin
              count_d = count_q - bklt_pkg::CNT_W'(1);
            end
          end
        end else if (idx_inc < count_q) begin
          idx_d   = idx_inc;
          state_d = bklt_pkg::S_SCAN_RD;
        end else begin
          state_d = bklt_pkg::S_DONE;
        end
      end

      // compaction: entry idx+1 moves down to idx
      bklt_pkg::S_SHIFT_RD: begin
        ram_o.raddr = idx_inc[bklt_pkg::ADDR_W-1:0];
        state_d     = bklt_pkg::S_SHIFT_WR;
      end

      bklt_pkg::S_SHIFT_WR: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = idx_q[bklt_pkg::ADDR_W-1:0];
        ram_o.wdata = ram_rdata_i;
        if (idx_inc2 < count_q) begin
          idx_d   = idx_inc;
          state_d = bklt_pkg::S_SHIFT_RD;
        end else begin
          count_d = count_q - bklt_pkg::CNT_W'(1);
          state_d = bklt_pkg::S_DONE;
        end
      end

      bklt_pkg::S_FETCH: begin
        ok_d    = 1'b1;
        rk_d    = ram_rdata_i.key;
        rv_d    = ram_rdata_i.value;
        state_d = bklt_pkg::S_DONE;
      end

      bklt_pkg::S_DONE: begin
        // load the response beat once the output register is free
        if (!ovld_q || rsp.ready) begin
          ovld_d  = 1'b1;
          ook_d   = ok_q;
          okey_d  = rk_q;
          oval_d  = rv_q;
          ocnt_d  = count_q;
          state_d = bklt_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = bklt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bklt_pkg::S_IDLE;
      count_q  <= '0;
      cursor_q <= '0;
      ovld_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      cursor_q <= cursor_d;
      ovld_q   <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    key_q  <= key_d;
    idx_q  <= idx_d;
    ok_q   <= ok_d;
    rk_q   <= rk_d;
    rv_q   <= rv_d;
    ook_q  <= ook_d;
    okey_q <= okey_d;
    oval_q <= oval_d;
    ocnt_q <= ocnt_d;
  end

endmodule

FILE: hdl/bounded_keyed_list_table_top.sv
// ----------------------------------------------------------------------------
// bounded_keyed_list_table_top
// Bounded key/value table kept packed in insertion order, held in one RAM.
//
//   channel   dir  fields                                   beat
//   req_i     in   opcode, in_key, in_value                 valid & ready
//   rsp_o     out  ok, out_key, out_value, item_count       valid & ready
//   cfg       in   cfg_wdata_i (capacity)                   cfg_we_i
//
// One request at a time. Insert, clear and misses on an empty table go
// straight to the response; get first / get next read one entry first.
// Query and remove scan the RAM entry by entry (read, compare), and remove
// then compacts by moving each later entry down one place (read, write).
// Reset: count, cursor and capacity (DEPTH) clear at once; no RAM clearing.
// A held response stalls the next request only once it is finished.
// ----------------------------------------------------------------------------
module bounded_keyed_list_table_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bklt_pkg::CAP_W-1:0] cfg_wdata_i,
  bklt_in_if.sink                    req_i,
  bklt_out_if.source                 rsp_o
);

  logic [bklt_pkg::CAP_W-1:0] cap_q;
  bklt_pkg::ram_req_t         ram_req;
  bklt_pkg::entry_t           ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= bklt_pkg::CAP_W'(bklt_pkg::DEPTH);
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  bklt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cap_i       (cap_q),
    .req         (req_i),
    .rsp         (rsp_o),
    .ram_o       (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  bklt_ram #(
    .Depth (bklt_pkg::DEPTH),
    .Width ($bits(bklt_pkg::entry_t))
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

endmodule
